// File: rtl/fenwick_pkg.sv
// ----------------------------------------------------------------------------
// fenwick_pkg
// Shared types and constants for the Fenwick tree range-sum block.
// ----------------------------------------------------------------------------
package fenwick_pkg;

    localparam int unsigned MaxPositions = 1024;
    localparam int unsigned IdxW         = 11;
    localparam int unsigned PosW         = IdxW + 1;
    localparam int unsigned ValW         = 32;
    localparam int unsigned SumW         = 64;
    localparam int unsigned SizeReset    = 1024;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                   opcode;
        logic [IdxW-1:0]        index_a;
        logic [IdxW-1:0]        index_b;
        logic signed [ValW-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [SumW-1:0] range_sum;
        logic                   error;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic clr_en;
        logic walk_up;
        logic walk_down;
        logic start_qa;
        logic wb_en;
        logic acc_en;
        logic acc_sub;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic op_query;
        logic pos_zero;
        logic up_done;
        logic clr_last;
    } dp_status_t;

endpackage

// File: rtl/fenwick_ram.sv
// ----------------------------------------------------------------------------
// fenwick_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fenwick_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/fenwick_dp.sv
// ----------------------------------------------------------------------------
// fenwick_dp
// Datapath: size register, walk index, partial-sum memory, accumulator and
// result register.
// ----------------------------------------------------------------------------
module fenwick_dp #(
    parameter int unsigned MAX_POSITIONS = fenwick_pkg::MaxPositions
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [10:0]            cfg_wr_data,
    input  fenwick_pkg::in_item_t  in_data,
    input  fenwick_pkg::dp_cmd_t   cmd,
    output fenwick_pkg::dp_status_t st,
    output fenwick_pkg::out_item_t out_data
);
    import fenwick_pkg::*;

    localparam int unsigned AW       = $clog2(MAX_POSITIONS);
    localparam int unsigned LimitCap = (MAX_POSITIONS < 2047) ? MAX_POSITIONS : 2047;

    logic [IdxW-1:0]        size_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic                   op_reg;
    logic                   err_reg;
    logic [IdxW-1:0]        a_reg;
    logic [IdxW-1:0]        limit_reg;
    logic signed [ValW-1:0] value_reg;
    logic [PosW-1:0]        pos_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic [SumW-1:0]        acc_reg;
    out_item_t              out_reg;

    logic [IdxW-1:0] lim;
    logic            req_err;
    logic [PosW-1:0] low_bit;
    logic [PosW-1:0] pos_m1;
    logic [AW-1:0]   rd_addr;
    logic [SumW-1:0] rdata;
    logic [SumW-1:0] upd_sum;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [SumW-1:0] ram_wdata;

    assign lim = (size_reg > IdxW'(LimitCap)) ? IdxW'(LimitCap) : size_reg;

    always_comb
    begin
        if (in_data.opcode == OP_QUERY)
        begin
            req_err = (in_data.index_a == '0) || (in_data.index_b > lim)
                   || (in_data.index_a > in_data.index_b);
        end
        else
        begin
            req_err = (in_data.index_a == '0) || (in_data.index_a > lim);
        end
    end

    assign low_bit = pos_reg & (~pos_reg + PosW'(1));
    assign pos_m1  = pos_reg - PosW'(1);
    assign rd_addr = AW'(pos_m1);
    assign upd_sum = rdata + SumW'(value_reg);

    assign ram_we    = cmd.clr_en || cmd.wb_en;
    assign ram_waddr = cmd.clr_en ? clr_addr_reg : wr_addr_reg;
    assign ram_wdata = cmd.clr_en ? '0 : upd_sum;

    fenwick_ram #(
        .WIDTH (SumW),
        .DEPTH (MAX_POSITIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.walk_up || cmd.walk_down),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= IdxW'(SizeReset);
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            if (cmd.clr_en)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_data.opcode;
            err_reg   <= req_err;
            a_reg     <= in_data.index_a;
            limit_reg <= lim;
            value_reg <= in_data.value;
            acc_reg   <= '0;
            pos_reg   <= (in_data.opcode == OP_QUERY) ? {1'b0, in_data.index_b}
                                                      : {1'b0, in_data.index_a};
        end
        else
        begin
            if (cmd.walk_up)
            begin
                pos_reg     <= pos_reg + low_bit;
                wr_addr_reg <= rd_addr;
            end
            else if (cmd.walk_down)
            begin
                pos_reg <= pos_reg - low_bit;
            end
            else if (cmd.start_qa)
            begin
                pos_reg <= {1'b0, a_reg} - PosW'(1);
            end
            if (cmd.acc_en)
            begin
                acc_reg <= cmd.acc_sub ? (acc_reg - rdata) : (acc_reg + rdata);
            end
        end
        if (cmd.load_out)
        begin
            out_reg.range_sum <= (err_reg || (op_reg == OP_UPDATE)) ? '0 : acc_reg;
            out_reg.error     <= err_reg;
        end
    end

    assign st.err      = err_reg;
    assign st.op_query = (op_reg == OP_QUERY);
    assign st.pos_zero = (pos_reg == '0);
    assign st.up_done  = (pos_reg == '0) || (pos_reg > {1'b0, limit_reg});
    assign st.clr_last = (clr_addr_reg == AW'(MAX_POSITIONS - 1));
    assign out_data    = out_reg;

endmodule

// File: rtl/fenwick_ctrl.sv
// ----------------------------------------------------------------------------
// fenwick_ctrl
// Controller: clearing pass, update walk, two-phase query walk, result hand-off.
// ----------------------------------------------------------------------------
module fenwick_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  fenwick_pkg::dp_status_t st,
    output fenwick_pkg::dp_cmd_t    cmd
);
    import fenwick_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_UPD,
        S_QB,
        S_QA,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pend_reg;
    logic   pend_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (st.err)
                begin
                    state_next = S_FIN;
                end
                else if (st.op_query)
                begin
                    state_next = S_QB;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.wb_en = pend_reg;
                if (!st.up_done)
                begin
                    cmd.walk_up = 1'b1;
                    pend_next   = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_QB:
            begin
                cmd.acc_en = pend_reg;
                if (!st.pos_zero)
                begin
                    cmd.walk_down = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (!pend_reg)
                begin
                    cmd.start_qa = 1'b1;
                    state_next   = S_QA;
                end
            end
            S_QA:
            begin
                cmd.acc_en  = pend_reg;
                cmd.acc_sub = 1'b1;
                if (!st.pos_zero)
                begin
                    cmd.walk_down = 1'b1;
                    pend_next     = 1'b1;
                end
                else if (!pend_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/fenwick_tree_range_sum_top.sv
// ----------------------------------------------------------------------------
// fenwick_tree_range_sum_top
// Binary indexed tree of 64-bit partial sums: point add and range-sum query.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MAX_POSITIONS words of
// the partial-sum memory and holds in_stall high. Items are then taken one at
// a time; the single read port of the memory is walked one tree node per cycle.
// An update walks upward over n nodes, n being at most log2(size) + 1; a query
// makes two prefix walks, down from index_b and then down from index_a - 1,
// the second one empty when the range starts at position 1; a rejected item
// skips the walks. The result waits in an output register, so the next item
// is taken while it is still stalled.
module fenwick_tree_range_sum_top #(
    parameter int unsigned MAX_POSITIONS = fenwick_pkg::MaxPositions
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [10:0]            cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  fenwick_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output fenwick_pkg::out_item_t out_data
);
    import fenwick_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    fenwick_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    fenwick_dp #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .cmd         (cmd),
        .st          (st),
        .out_data    (out_data)
    );

`ifndef SYNTH
    a_err_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> out_data.range_sum == '0)
        else $error("error result with nonzero sum");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !cmd.wb_en && !cmd.clr_en)
        else $error("memory write while idle");

    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wb_en && cmd.clr_en))
        else $error("clear and update write together");

    a_load_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid && !in_stall)
        else $error("result load did not return to idle");
`endif

endmodule
